// ===== hw/rtl/mtld_pkg.sv =====
`timescale 1ns / 1ps

package mtld_pkg;

  typedef enum logic [1:0] {
    MODE_BOUNDARY = 2'd0,
    MODE_GENERIC  = 2'd1,
    MODE_POSITION = 2'd2,
    MODE_HUNT     = 2'd3
  } mode_t;

  localparam logic [1:0] KIND_GENERIC  = 2'd0;
  localparam logic [1:0] KIND_POSITION = 2'd1;
  localparam logic [1:0] KIND_EMPTY    = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  localparam logic [7:0] HASH_BYTE = 8'h23;

  localparam logic [1:0] HASH_RUN_FULL = 2'd2;

  localparam logic CFG_POSITION_TYPE   = 1'b0;
  localparam logic CFG_POSITION_LENGTH = 1'b1;

  localparam logic [6:0] POSITION_TYPE_RESET   = 7'd1;
  localparam logic [7:0] POSITION_LENGTH_RESET = 8'd16;

endpackage

// ===== hw/rtl/marker_type_length_deframer_top.sv =====
`timescale 1ns / 1ps

// deframer for a received byte stream: "###" markers, a type byte, then payload
// input channel: in_valid / in_stall with rx_byte, one byte per item
// output channel: out_valid / out_stall with kind, payload_byte, last
//   kind 0 generic payload byte, 1 position payload byte, 2 empty generic
//   message, 3 error on a bad type or marker; last marks a message's final item
// a byte causes at most one output item; marker bytes cause none
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data
//   index 0 position_type (cfg_data[6:0]), index 1 position_length
//   cfg_ready is always high; write only while the block is idle
// path: an accepted item waits in the input register, is processed into the output
//   register when that is free, and leaves from there
// throughput: one byte per cycle while the output is not stalled, set by the
//   input register and output register pair with the state update between them
// reset: back to the message boundary, registers to type 1 and length 16
// a stalled output holds the result; the input register then holds its byte
//   and in_stall rises, so nothing is lost while the receiver stalls
module marker_type_length_deframer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] payload_byte,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import mtld_pkg::*;

  logic [6:0] position_type;
  logic [7:0] position_length;

  logic       in_reg_valid;
  logic [7:0] in_reg_byte;

  mode_t      mode;
  mode_t      mode_next;
  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;
  logic [1:0] hash_run;
  logic [1:0] hash_run_next;

  logic       res_valid;
  logic [1:0] res_kind;
  logic [7:0] res_byte;
  logic       res_last;

  logic       out_free;
  logic       fire;
  logic       is_hash;
  logic       fin;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign fire      = in_reg_valid && out_free;
  assign in_stall  = in_reg_valid && !out_free;
  assign is_hash   = (in_reg_byte == HASH_BYTE);
  assign fin       = (bytes_left <= 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      position_type   <= POSITION_TYPE_RESET;
      position_length <= POSITION_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POSITION_TYPE:   position_type   <= cfg_data[6:0];
        CFG_POSITION_LENGTH: position_length <= cfg_data;
        default:             position_length <= position_length;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_byte <= rx_byte;
    end
  end

  // next mode
  always_comb begin
    mode_next = mode;
    unique case (mode)
      MODE_GENERIC, MODE_POSITION: begin
        if (fin) begin
          mode_next = MODE_BOUNDARY;
        end
      end
      MODE_HUNT: begin
        if (is_hash && hash_run == HASH_RUN_FULL) begin
          mode_next = MODE_BOUNDARY;
        end
      end
      MODE_BOUNDARY: begin
        priority if (is_hash) begin
          mode_next = MODE_BOUNDARY;
        end else if (hash_run != 2'd0) begin
          mode_next = MODE_HUNT;
        end else if (in_reg_byte[7]) begin
          if (in_reg_byte[6:0] != 7'd0) begin
            mode_next = MODE_GENERIC;
          end
        end else if (in_reg_byte[6:0] == position_type) begin
          if (position_length != 8'd0) begin
            mode_next = MODE_POSITION;
          end
        end else begin
          mode_next = MODE_HUNT;
        end
      end
      default: mode_next = mode;
    endcase
  end

  // counters and result
  always_comb begin
    bytes_left_next = bytes_left;
    hash_run_next   = hash_run;
    res_valid       = 1'b0;
    res_kind        = KIND_ERROR;
    res_byte        = 8'd0;
    res_last        = 1'b1;
    unique case (mode)
      MODE_GENERIC, MODE_POSITION: begin
        res_valid       = 1'b1;
        res_kind        = (mode == MODE_GENERIC) ? KIND_GENERIC : KIND_POSITION;
        res_byte        = in_reg_byte;
        res_last        = fin;
        bytes_left_next = fin ? 8'd0 : bytes_left - 8'd1;
      end
      MODE_HUNT: begin
        if (is_hash && hash_run != HASH_RUN_FULL) begin
          hash_run_next = hash_run + 2'd1;
        end else begin
          hash_run_next = 2'd0;
        end
      end
      MODE_BOUNDARY: begin
        priority if (is_hash) begin
          hash_run_next = (hash_run == HASH_RUN_FULL) ? 2'd0 : hash_run + 2'd1;
        end else if (hash_run != 2'd0) begin
          hash_run_next = 2'd0;
          res_valid     = 1'b1;
        end else if (in_reg_byte[7]) begin
          if (in_reg_byte[6:0] == 7'd0) begin
            res_valid = 1'b1;
            res_kind  = KIND_EMPTY;
          end else begin
            bytes_left_next = {1'b0, in_reg_byte[6:0]};
          end
        end else if (in_reg_byte[6:0] == position_type) begin
          if (position_length != 8'd0) begin
            bytes_left_next = position_length;
          end
        end else begin
          hash_run_next = 2'd0;
          res_valid     = 1'b1;
        end
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_BOUNDARY;
      bytes_left <= 8'd0;
      hash_run   <= 2'd0;
    end else if (fire) begin
      mode       <= mode_next;
      bytes_left <= bytes_left_next;
      hash_run   <= hash_run_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      kind         <= res_kind;
      payload_byte <= res_byte;
      last         <= res_last;
    end
  end

  a_hash_run_range: assert property (@(posedge clk) disable iff (rst)
    hash_run != 2'd3)
    else $error("hash run count out of range");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_GENERIC || mode == MODE_POSITION) |-> bytes_left != 8'd0)
    else $error("payload mode with no bytes left");

  a_error_hunts: assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid && res_kind == KIND_ERROR) |=> mode == MODE_HUNT)
    else $error("error result without hunt");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_reg_valid && out_valid && out_stall))
    else $error("input stalled without a full output");

endmodule

// ===== tb/sv/tb_marker_type_length_deframer_top.sv =====
`timescale 1ns / 1ps

module tb_marker_type_length_deframer_top;
  import mtld_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } deframed_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic       last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  logic [7:0] rx_pending[$];
  deframed_t  deframed_expected[$];
  int         phase_bytes;
  int         fail_count = 0;
  int         cycle_count = 0;
  logic       calm = 1'b0;

  // predictor state and register copies
  mode_t      frame_mode;
  logic [7:0] bytes_left;
  logic [1:0] hash_run;
  logic [6:0] pos_type;
  logic [7:0] pos_len;

  marker_type_length_deframer_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void expect_item(input logic [1:0] k, input logic [7:0] d, input logic l);
    deframed_t e;
    e.kind = k;
    e.data = d;
    e.last = l;
    deframed_expected.insert(deframed_expected.size(), e);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic       fin;
    logic [1:0] k;
    case (frame_mode)
      MODE_GENERIC, MODE_POSITION: begin
        k = (frame_mode == MODE_GENERIC) ? KIND_GENERIC : KIND_POSITION;
        fin = (bytes_left <= 8'd1);
        bytes_left = bytes_left - 8'd1;
        if (fin) begin
          bytes_left = 8'd0;
          frame_mode = MODE_BOUNDARY;
        end
        expect_item(k, b, fin);
      end
      MODE_HUNT: begin
        if (b == HASH_BYTE) begin
          if (hash_run == HASH_RUN_FULL) begin
            hash_run = 2'd0;
            frame_mode = MODE_BOUNDARY;
          end else begin
            hash_run = hash_run + 2'd1;
          end
        end else begin
          hash_run = 2'd0;
        end
      end
      default: begin
        if (b == HASH_BYTE) begin
          if (hash_run == HASH_RUN_FULL) hash_run = 2'd0;
          else hash_run = hash_run + 2'd1;
        end else if (hash_run != 2'd0) begin
          hash_run = 2'd0;
          frame_mode = MODE_HUNT;
          expect_item(KIND_ERROR, 8'h00, 1'b1);
        end else if (b[7]) begin
          if (b[6:0] == 7'd0) begin
            expect_item(KIND_EMPTY, 8'h00, 1'b1);
          end else begin
            bytes_left = {1'b0, b[6:0]};
            frame_mode = MODE_GENERIC;
          end
        end else if (b[6:0] == pos_type) begin
          if (pos_len != 8'd0) begin
            bytes_left = pos_len;
            frame_mode = MODE_POSITION;
          end
        end else begin
          hash_run = 2'd0;
          frame_mode = MODE_HUNT;
          expect_item(KIND_ERROR, 8'h00, 1'b1);
        end
      end
    endcase
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (rx_pending.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
        in_valid <= 1'b1;
        rx_byte <= rx_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 11);
  end

  // monitor
  always @(posedge clk) begin
    deframed_t e;
    if (rst) begin
      frame_mode = MODE_BOUNDARY;
      bytes_left = 8'd0;
      hash_run = 2'd0;
      pos_type = POSITION_TYPE_RESET;
      pos_len = POSITION_LENGTH_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_POSITION_TYPE) pos_type = cfg_data[6:0];
        else pos_len = cfg_data;
      end
      if (in_valid && !in_stall) deframe_byte(rx_byte);
      if (out_valid && !out_stall) begin
        if (deframed_expected.size() == 0) begin
          $error("unexpected item: kind %0d, payload_byte %0h, last %0b",
                 kind, payload_byte, last);
          fail_count++;
        end else begin
          e = deframed_expected.pop_front();
          if (kind !== e.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", e.kind, kind);
            fail_count++;
          end
          if (payload_byte !== e.data) begin
            $error("payload_byte mismatch: expected %0h, actual %0h", e.data, payload_byte);
            fail_count++;
          end
          if (last !== e.last) begin
            $error("last mismatch: expected %0b, actual %0b", e.last, last);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void push_byte(input logic [7:0] b);
    rx_pending.insert(rx_pending.size(), b);
    phase_bytes++;
  endfunction

  function automatic void push_bytes(input logic [255:0] pack, input int n);
    for (int i = n - 1; i >= 0; i--) push_byte(pack[8*i +: 8]);
  endfunction

  function automatic logic [7:0] hashy_byte();
    if ($urandom_range(99) < 30) return HASH_BYTE;
    return 8'($urandom_range(255));
  endfunction

  function automatic void add_marker();
    repeat (3) push_byte(HASH_BYTE);
  endfunction

  function automatic int generic_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 127);
  endfunction

  function automatic void add_generic(input int len);
    push_byte({1'b1, len[6:0]});
    repeat (len) push_byte(8'($urandom_range(255)));
  endfunction

  function automatic void add_position();
    if ({1'b0, pos_type} == HASH_BYTE) begin
      add_generic(generic_len());
    end else begin
      push_byte({1'b0, pos_type});
      repeat (pos_len) push_byte(8'($urandom_range(255)));
    end
  endfunction

  function automatic void add_hunt_tail();
    repeat ($urandom_range(0, 5)) push_byte(hashy_byte());
    add_marker();
  endfunction

  function automatic void add_unknown();
    logic [7:0] b;
    do b = 8'($urandom_range(127)); while (b[6:0] == pos_type || b == HASH_BYTE);
    push_byte(b);
    add_hunt_tail();
  endfunction

  function automatic void add_partial();
    logic [7:0] b;
    repeat ($urandom_range(1, 2)) push_byte(HASH_BYTE);
    do b = 8'($urandom_range(255)); while (b == HASH_BYTE);
    push_byte(b);
    add_hunt_tail();
  endfunction

  function automatic void gen_traffic(input int target);
    int r;
    phase_bytes = 0;
    while (phase_bytes < target) begin
      if ($urandom_range(99) < 40) add_marker();
      r = $urandom_range(99);
      if (r < 45) begin
        add_generic(generic_len());
      end else if (r < 70) begin
        if (pos_len > 8'd40 && $urandom_range(9) != 0) add_generic(generic_len());
        else add_position();
      end else if (r < 78) begin
        push_byte(8'h80);
      end else if (r < 86) begin
        add_unknown();
      end else if (r < 93) begin
        add_partial();
      end else begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
      end
    end
  endfunction

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] type_data, input logic [7:0] len_data);
    write_reg(CFG_POSITION_TYPE, type_data);
    write_reg(CFG_POSITION_LENGTH, len_data);
    @(negedge clk);
  endtask

  task automatic drain_all();
    do @(negedge clk);
    while (rx_pending.size() != 0 || in_valid || deframed_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    gen_traffic(120);
    drain_all();

    configure(8'h00, 8'd1);
    push_bytes(256'({8'h23, 8'h23, 8'h23, 8'h23, 8'h23, 8'h23, 8'h80, 8'h81, 8'hFF,
                     8'h00, 8'hAA, 8'h23, 8'h05, 8'h23, 8'h23, 8'h41, 8'h23, 8'h23,
                     8'h23, 8'h23, 8'h23, 8'h80, 8'h23, 8'h23, 8'h23, 8'h7E, 8'h23,
                     8'h23, 8'h23}), 29);
    drain_all();
    gen_traffic(100);
    drain_all();

    configure(8'h7F, 8'hFF);
    add_generic(127);
    add_position();
    gen_traffic(100);
    drain_all();

    // position type equal to the marker byte
    configure(8'h23, 8'd3);
    push_bytes(256'({8'h23, 8'h23, 8'h23, 8'h23, 8'h10, 8'h23, 8'h23, 8'h23,
                     8'h83, 8'h01, 8'h02, 8'h03}), 12);
    gen_traffic(100);
    drain_all();

    // position message with no payload
    configure(8'hD5, 8'd0);
    push_bytes(256'({8'h55, 8'h80, 8'h55, 8'h81, 8'h00}), 5);
    gen_traffic(100);
    drain_all();

    for (int p = 0; p < 6; p++) begin
      configure(8'($urandom_range(255)),
                ($urandom_range(99) < 85) ? 8'($urandom_range(1, 12))
                                          : 8'($urandom_range(13, 64)));
      calm = (p == 3);
      gen_traffic(80);
      drain_all();
      calm = 1'b0;
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
